@@ src/pitt_pkg.sv @@
`default_nettype none

package pitt_pkg;

   // coordinate and datapath widths
   localparam int COORD_BITS = 16;
   localparam int DIFF_W     = COORD_BITS + 1;        // vertex offset
   localparam int PROD_W     = 2 * DIFF_W;            // one cross product term
   localparam int CROSS_W    = PROD_W + 1;            // cross product component
   localparam int LO_W       = CROSS_W / 2;           // low slice, unsigned
   localparam int HI_W       = CROSS_W - LO_W;        // high slice, signed
   localparam int HH_W       = 2 * HI_W;
   localparam int HL_W       = HI_W + LO_W + 1;
   localparam int LL_W       = 2 * LO_W;
   localparam int TERM_W     = 2 * CROSS_W;           // one dot product term
   localparam int DOT_W      = TERM_W + 2;            // sum of three terms

   localparam int NUM_AXES   = 3;
   localparam int NUM_SIDES  = 3;
   localparam int NUM_STAGES = 5;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [DIFF_W-1:0]     diff_type;
   typedef logic signed [PROD_W-1:0]     prod_type;
   typedef logic signed [CROSS_W-1:0]    cross_type;
   typedef logic signed [HH_W-1:0]       hh_type;
   typedef logic signed [HL_W-1:0]       hl_type;
   typedef logic        [LL_W-1:0]       ll_type;
   typedef logic signed [TERM_W-1:0]     term_type;
   typedef logic signed [DOT_W-1:0]      dot_type;

endpackage

`default_nettype wire

@@ src/pitt_if.sv @@
`default_nettype none

// input channel: point and three triangle vertices
interface pitt_req_if import pitt_pkg::*; ();
   logic      valid;
   logic      ready;
   coord_type point_x;
   coord_type point_y;
   coord_type point_z;
   coord_type first_x;
   coord_type first_y;
   coord_type first_z;
   coord_type second_x;
   coord_type second_y;
   coord_type second_z;
   coord_type third_x;
   coord_type third_y;
   coord_type third_z;

   modport source (
      output valid, point_x, point_y, point_z, first_x, first_y, first_z,
             second_x, second_y, second_z, third_x, third_y, third_z,
      input  ready
   );
   modport sink (
      input  valid, point_x, point_y, point_z, first_x, first_y, first_z,
             second_x, second_y, second_z, third_x, third_y, third_z,
      output ready
   );
endinterface

// result channel: one inside flag per beat
interface pitt_rsp_if;
   logic valid;
   logic ready;
   logic inside_res;

   modport source (output valid, inside_res, input ready);
   modport sink (input valid, inside_res, output ready);
endinterface

`default_nettype wire

@@ src/point_in_triangle_test_top.sv @@
// point_in_triangle_test_top: same-side point-in-triangle test in 3d
//
// req_chan carries one beat per test: point p and vertices a (first),
// b (second) and c (third), each coordinate signed COORD_BITS wide.
// rsp_chan returns one beat per test, in order: inside_res is 1 when p lies
// on the inner side of edges bc and ca, ca being tested twice and ab never
// (on an edge, or any point against a degenerate triangle: inside), else 0.
//
// pipeline: a req beat passes the stages offsets, cross products, dot
//   partial products, dot terms and dot sum, then shows as rsp valid.
// throughput: one test per cycle while rsp_chan is not stalled; the
//   multipliers are 17 x 17 (cross products), up to 18 x 18 (dot slices).
// stall: every stage has its own valid bit and loads whenever it is empty
//   or its successor moves, so bubbles close up while rsp_chan is stalled;
//   req_chan keeps taking beats until all five stages hold an item, and the
//   waiting result is held unchanged in the output stage.
// reset: synchronous, clears all valid bits; the pipeline is empty and
//   req_chan.ready is high after reset.
`default_nettype none

module point_in_triangle_test_top import pitt_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   pitt_req_if.sink      req_chan,
   pitt_rsp_if.source    rsp_chan
);

   // vertex order in the lookup arrays: point, first, second, third
   localparam int VTX_POINT  = 0;
   localparam int VTX_FIRST  = 1;
   localparam int VTX_SECOND = 2;
   localparam int VTX_THIRD  = 3;

   // per edge: start vertex, end vertex, opposite vertex
   localparam int START_IDX [NUM_SIDES] = '{VTX_SECOND, VTX_FIRST, VTX_THIRD};
   localparam int END_IDX   [NUM_SIDES] = '{VTX_THIRD, VTX_THIRD, VTX_FIRST};
   localparam int OPP_IDX   [NUM_SIDES] = '{VTX_FIRST, VTX_SECOND, VTX_SECOND};

   // one component of a cross b: a1 * b2 - a2 * b1
   function automatic cross_type cross_comp(diff_type a1, diff_type b2,
                                            diff_type a2, diff_type b1);
      prod_type m1;
      prod_type m2;
      m1 = a1 * b2;
      m2 = a2 * b1;
      return CROSS_W'(m1) - CROSS_W'(m2);
   endfunction

   // ------------------------------------------------------------------
   // handshake: per-stage valid bits, ready ripples back from the output
   // ------------------------------------------------------------------
   logic [NUM_STAGES-1:0] stage_valid_ff;
   logic [NUM_STAGES-1:0] stage_valid_in;
   logic [NUM_STAGES-1:0] stage_ready;

   always_comb begin
      stage_ready[NUM_STAGES-1] = !stage_valid_ff[NUM_STAGES-1] || rsp_chan.ready;
      for (int s = NUM_STAGES - 2; s >= 0; s--) begin
         stage_ready[s] = !stage_valid_ff[s] || stage_ready[s+1];
      end
   end

   always_comb begin
      stage_valid_in = stage_valid_ff;
      if (stage_ready[0]) begin
         stage_valid_in[0] = req_chan.valid;
      end
      for (int s = 1; s < NUM_STAGES; s++) begin
         if (stage_ready[s]) begin
            stage_valid_in[s] = stage_valid_ff[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= '0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   assign req_chan.ready = stage_ready[0];

   // ------------------------------------------------------------------
   // stage 1: edge vector, point offset and opposite vertex offset
   // ------------------------------------------------------------------
   coord_type vtx [4][NUM_AXES];

   always_comb begin
      vtx[VTX_POINT][0]  = req_chan.point_x;
      vtx[VTX_POINT][1]  = req_chan.point_y;
      vtx[VTX_POINT][2]  = req_chan.point_z;
      vtx[VTX_FIRST][0]  = req_chan.first_x;
      vtx[VTX_FIRST][1]  = req_chan.first_y;
      vtx[VTX_FIRST][2]  = req_chan.first_z;
      vtx[VTX_SECOND][0] = req_chan.second_x;
      vtx[VTX_SECOND][1] = req_chan.second_y;
      vtx[VTX_SECOND][2] = req_chan.second_z;
      vtx[VTX_THIRD][0]  = req_chan.third_x;
      vtx[VTX_THIRD][1]  = req_chan.third_y;
      vtx[VTX_THIRD][2]  = req_chan.third_z;
   end

   diff_type edge_vec_ff [NUM_SIDES][NUM_AXES];
   diff_type pt_off_ff   [NUM_SIDES][NUM_AXES];
   diff_type opp_off_ff  [NUM_SIDES][NUM_AXES];

   always_ff @(posedge clock) begin
      if (stage_ready[0]) begin
         for (int k = 0; k < NUM_SIDES; k++) begin
            for (int a = 0; a < NUM_AXES; a++) begin
               edge_vec_ff[k][a] <= DIFF_W'(vtx[END_IDX[k]][a])
                                  - DIFF_W'(vtx[START_IDX[k]][a]);
               pt_off_ff[k][a]   <= DIFF_W'(vtx[VTX_POINT][a])
                                  - DIFF_W'(vtx[START_IDX[k]][a]);
               opp_off_ff[k][a]  <= DIFF_W'(vtx[OPP_IDX[k]][a])
                                  - DIFF_W'(vtx[START_IDX[k]][a]);
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // stage 2: cross products e x (p - s) and e x (q - s), exact width
   // ------------------------------------------------------------------
   cross_type cp_pt_ff  [NUM_SIDES][NUM_AXES];
   cross_type cp_opp_ff [NUM_SIDES][NUM_AXES];

   always_ff @(posedge clock) begin
      if (stage_ready[1]) begin
         for (int k = 0; k < NUM_SIDES; k++) begin
            for (int a = 0; a < NUM_AXES; a++) begin
               cp_pt_ff[k][a] <= cross_comp(
                  edge_vec_ff[k][(a+1)%NUM_AXES], pt_off_ff[k][(a+2)%NUM_AXES],
                  edge_vec_ff[k][(a+2)%NUM_AXES], pt_off_ff[k][(a+1)%NUM_AXES]);
               cp_opp_ff[k][a] <= cross_comp(
                  edge_vec_ff[k][(a+1)%NUM_AXES], opp_off_ff[k][(a+2)%NUM_AXES],
                  edge_vec_ff[k][(a+2)%NUM_AXES], opp_off_ff[k][(a+1)%NUM_AXES]);
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // stage 3: dot product terms split into four narrow partial products
   //   x = xh * 2^LO_W + xl, xh signed, xl unsigned
   // ------------------------------------------------------------------
   hh_type pp_hh_ff [NUM_SIDES][NUM_AXES];
   hl_type pp_hl_ff [NUM_SIDES][NUM_AXES];
   hl_type pp_lh_ff [NUM_SIDES][NUM_AXES];
   ll_type pp_ll_ff [NUM_SIDES][NUM_AXES];

   always_ff @(posedge clock) begin
      if (stage_ready[2]) begin
         for (int k = 0; k < NUM_SIDES; k++) begin
            for (int a = 0; a < NUM_AXES; a++) begin
               pp_hh_ff[k][a] <= $signed(cp_pt_ff[k][a][CROSS_W-1:LO_W])
                               * $signed(cp_opp_ff[k][a][CROSS_W-1:LO_W]);
               pp_hl_ff[k][a] <= $signed(cp_pt_ff[k][a][CROSS_W-1:LO_W])
                               * $signed({1'b0, cp_opp_ff[k][a][LO_W-1:0]});
               pp_lh_ff[k][a] <= $signed({1'b0, cp_pt_ff[k][a][LO_W-1:0]})
                               * $signed(cp_opp_ff[k][a][CROSS_W-1:LO_W]);
               pp_ll_ff[k][a] <= cp_pt_ff[k][a][LO_W-1:0]
                               * cp_opp_ff[k][a][LO_W-1:0];
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // stage 4: reassemble each full-width dot term
   // ------------------------------------------------------------------
   term_type term_ff [NUM_SIDES][NUM_AXES];

   always_ff @(posedge clock) begin
      if (stage_ready[3]) begin
         for (int k = 0; k < NUM_SIDES; k++) begin
            for (int a = 0; a < NUM_AXES; a++) begin
               term_ff[k][a] <= (TERM_W'(pp_hh_ff[k][a]) << (2 * LO_W))
                              + ((TERM_W'(pp_hl_ff[k][a]) + TERM_W'(pp_lh_ff[k][a]))
                                 << LO_W)
                              + TERM_W'(pp_ll_ff[k][a]);
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // stage 5: sum the three terms per edge, any negative sum is outside
   // ------------------------------------------------------------------
   dot_type           dot_sum [NUM_SIDES];
   logic [NUM_SIDES-1:0] side_neg;
   logic              inside_ff;

   always_comb begin
      for (int k = 0; k < NUM_SIDES; k++) begin
         dot_sum[k]  = DOT_W'(term_ff[k][0]) + DOT_W'(term_ff[k][1])
                     + DOT_W'(term_ff[k][2]);
         side_neg[k] = dot_sum[k][DOT_W-1];
      end
   end

   always_ff @(posedge clock) begin
      if (stage_ready[4]) begin
         inside_ff <= ~|side_neg;
      end
   end

   assign rsp_chan.valid      = stage_valid_ff[NUM_STAGES-1];
   assign rsp_chan.inside_res = inside_ff;

`ifndef SYNTHESIS
   // an empty first stage always takes a beat
   a_empty_takes: assert property (@(posedge clock) disable iff (reset)
      !stage_valid_ff[0] |-> req_chan.ready)
      else $error("empty first stage refused a beat");

   // an accepted beat lands in the first stage
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> stage_valid_ff[0])
      else $error("accepted beat lost at entry");

   // an item in the dot term stage waiting behind a stalled output stays put
   a_hold_mid: assert property (@(posedge clock) disable iff (reset)
      (stage_valid_ff[3] && !stage_ready[4]) |=> stage_valid_ff[3])
      else $error("item dropped in dot term stage");

   // a result taken with nothing behind it leaves the output empty
   a_drain: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.ready && !stage_valid_ff[3])
      |=> !rsp_chan.valid)
      else $error("result repeated after drain");
`endif

endmodule

`default_nettype wire
